### sv/gbms_pkg.sv
package gbms_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_LOCATION        = 3'd0;
  localparam logic [2:0] REG_LOCATION_TREND  = 3'd1;
  localparam logic [2:0] REG_SCALE           = 3'd2;
  localparam logic [2:0] REG_SHAPE           = 3'd3;
  localparam logic [2:0] REG_ZERO_FRACTION   = 3'd4;
  localparam logic [2:0] REG_SAMPLES_PER_SET = 3'd5;
  localparam logic [2:0] REG_SET_COUNT       = 3'd6;

  // Operation codes of the bit-serial unit.
  localparam logic SER_DIV  = 1'b0;
  localparam logic SER_SQRT = 1'b1;

  typedef struct packed {
    logic [31:0] location;
    logic [31:0] location_trend;
    logic [31:0] scale;
    logic [31:0] shape;
    logic [31:0] zero_fraction;
  } gbms_cfg_t;

  typedef struct packed {
    logic        start;
    logic        op;
    logic [6:0]  steps;
    logic [63:0] num;
    logic [31:0] den;
    logic [31:0] rem0;
  } gbms_ser_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [31:0] rem;
    logic [31:0] root;
  } gbms_ser_rsp_t;

endpackage

### sv/gbms_mul.sv
module gbms_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

### sv/gbms_serial.sv
module gbms_serial
  import gbms_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  gbms_ser_req_t req,
  output gbms_ser_rsp_t rsp
);

  logic        run;
  logic        op;
  logic [6:0]  cnt;
  logic [63:0] quo;
  logic [33:0] rem;
  logic [31:0] root;
  logic [31:0] den;
  logic        done;

  logic [32:0] dtrial;
  logic        dge;
  logic [35:0] sacc;
  logic [35:0] strial;
  logic        sge;
  logic [35:0] sdiff;

  always_comb begin
    dtrial = {rem[31:0], quo[63]};
    dge    = dtrial >= {1'b0, den};
    sacc   = {rem, quo[63:62]};
    strial = {2'b00, root, 2'b01};
    sge    = sacc >= strial;
    sdiff  = sacc - strial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.steps;
      end else if (run) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      quo  <= req.num;
      rem  <= {2'b00, req.rem0};
      den  <= req.den;
      root <= '0;
    end else if (run) begin
      if (op == SER_DIV) begin
        rem <= dge ? {1'b0, dtrial - {1'b0, den}} : {1'b0, dtrial};
        quo <= {quo[62:0], dge};
      end else begin
        rem  <= sge ? sdiff[33:0] : sacc[33:0];
        root <= {root[30:0], sge};
        quo  <= {quo[61:0], 2'b00};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[31:0];
  assign rsp.root = root;

endmodule

### sv/gbms_core.sv
module gbms_core
  import gbms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] sample,
  input  logic [16:0] pos_plus1,
  input  gbms_cfg_t   cfg,
  input  logic        take,
  output logic        idle,
  output logic        done,
  output logic [31:0] value
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIVS = 5'd1;
  localparam logic [4:0] S_NORM = 5'd2;
  localparam logic [4:0] S_SQ   = 5'd3;
  localparam logic [4:0] S_SQW  = 5'd4;
  localparam logic [4:0] S_LOGD = 5'd5;
  localparam logic [4:0] S_LOC  = 5'd6;
  localparam logic [4:0] S_LOCW = 5'd7;
  localparam logic [4:0] S_G1   = 5'd8;
  localparam logic [4:0] S_G2   = 5'd9;
  localparam logic [4:0] S_G3   = 5'd10;
  localparam logic [4:0] S_G4   = 5'd11;
  localparam logic [4:0] S_G5   = 5'd12;
  localparam logic [4:0] S_G6   = 5'd13;
  localparam logic [4:0] S_E1   = 5'd14;
  localparam logic [4:0] S_E2   = 5'd15;
  localparam logic [4:0] S_E3   = 5'd16;
  localparam logic [4:0] S_X1   = 5'd17;
  localparam logic [4:0] S_X2   = 5'd18;
  localparam logic [4:0] S_X3   = 5'd19;
  localparam logic [4:0] S_X4   = 5'd20;
  localparam logic [4:0] S_X5   = 5'd21;
  localparam logic [4:0] S_D1   = 5'd22;
  localparam logic [4:0] S_Q1   = 5'd23;
  localparam logic [4:0] S_Q2   = 5'd24;
  localparam logic [4:0] S_Q3   = 5'd25;
  localparam logic [4:0] S_Q4   = 5'd26;
  localparam logic [4:0] S_Q5   = 5'd27;
  localparam logic [4:0] S_Q6   = 5'd28;
  localparam logic [4:0] S_FIN  = 5'd29;
  localparam logic [4:0] S_DONE = 5'd30;

  localparam logic [31:0] LN2_Q32    = 32'hB172_17F7;
  localparam logic [37:0] A_BASE     = 38'h20_0000_0000;
  localparam logic [40:0] C_OFFSET   = 41'h040_0000_0000;
  localparam logic [43:0] E_SAT      = 44'h01F_0000_0000;
  localparam logic [50:0] TERM_LIMIT = 51'h4_0000_0000_0000;
  localparam logic [95:0] PROD_LIMIT = 96'h40_0000_0000_0000;

  // log2 of ln 2 in Q.32, by the same square-and-compare routine as the datapath.
  function automatic logic [39:0] log2_of_ln2();
    logic [31:0] m;
    logic [63:0] sq;
    logic [31:0] fr;
    m  = LN2_Q32;
    fr = '0;
    for (int i = 0; i < 32; i++) begin
      sq = (64'(m) * 64'(m)) >> 31;
      fr = {fr[30:0], sq[32]};
      m  = sq[32] ? sq[32:1] : sq[31:0];
    end
    return {8'd31, fr};
  endfunction

  localparam logic [39:0] LOG2_LN2 = log2_of_ln2();

  logic [4:0]  state;
  logic        pass;
  logic [37:0] lx;
  logic [5:0]  cexp;
  logic [31:0] m;
  logic [31:0] frac;
  logic [4:0]  k;
  logic        neg_c;
  logic [38:0] mc;
  logic [49:0] loc_t;
  logic [31:0] tlo;
  logic [39:0] lnmag;
  logic [35:0] elo;
  logic [31:0] f;
  logic [12:0] n;
  logic [31:0] r;
  logic [4:0]  j;
  logic [63:0] pw;
  logic        pos_pm1;
  logic [63:0] x;
  logic [63:0] q1;
  logic [31:0] r1;
  logic [63:0] plo;
  logic [54:0] sq;
  logic [50:0] tmag;
  logic        term_neg;
  logic [31:0] val;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  gbms_ser_req_t sreq;
  gbms_ser_rsp_t srsp;

  logic [32:0] sqt;
  logic [37:0] lg;
  logic [40:0] cval;
  logic [40:0] cneg;
  logic        neg_k;
  logic [31:0] mk;
  logic        trend_neg;
  logic [31:0] trend_mag;
  logic [49:0] ploc;
  logic [43:0] emag;
  logic [44:0] e_val;
  logic        e_sat;
  logic [13:0] sh;
  logic [13:0] amt;
  logic [63:0] pw_calc;
  logic [64:0] pm1;
  logic [64:0] pm1_neg;
  logic [95:0] full;
  logic [55:0] qsum;
  logic [51:0] qsh;
  logic [52:0] vsum;
  logic [52:0] tterm;
  logic [32:0] rr;

  gbms_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  gbms_serial u_serial (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  always_comb begin
    sqt       = prod[63:31];
    lg        = {cexp, frac};
    cval      = {3'b000, lg} + {1'b0, LOG2_LN2} - C_OFFSET;
    cneg      = 41'd0 - cval;
    neg_k     = cfg.shape[31];
    mk        = neg_k ? 32'd0 - cfg.shape : cfg.shape;
    trend_neg = cfg.location_trend[31];
    trend_mag = trend_neg ? 32'd0 - cfg.location_trend : cfg.location_trend;
    ploc      = trend_neg ? 50'd0 - {2'b00, prod[47:0]} : {2'b00, prod[47:0]};
    emag      = {1'b0, prod[38:0], 4'b0000} + {8'd0, elo};
    e_val     = (neg_c != neg_k) ? {1'b0, emag} : 45'd0 - {1'b0, emag};
    e_sat     = !e_val[44] && (e_val[43:0] >= E_SAT);
    sh        = {n[12], n} + 14'd1;
    amt       = 14'd0 - sh;
    if (!sh[13]) begin
      pw_calc = 64'(r) << sh[4:0];
    end else if (amt >= 14'd64) begin
      pw_calc = '0;
    end else begin
      pw_calc = 64'(r) >> amt[5:0];
    end
    pm1     = {1'b0, pw} - 65'h1_0000_0000;
    pm1_neg = 65'd0 - pm1;
    full    = {prod, 32'h0} + {32'h0, plo};
    qsum    = {1'b0, sq} + {24'd0, srsp.quo[31:0]};
    qsh     = qsum[55:4];
    tterm   = term_neg ? 53'd0 - {2'b00, tmag} : {2'b00, tmag};
    vsum    = {{3{loc_t[49]}}, loc_t} + tterm;
    rr      = f[j] ? {r, 1'b0} : {1'b0, r};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = m;
        mul_b = m;
      end
      S_LOC: begin
        mul_a = trend_mag;
        mul_b = 32'(pos_plus1);
      end
      S_G1: begin
        mul_a = LN2_Q32;
        mul_b = mc[31:0];
      end
      S_G2: begin
        mul_a = LN2_Q32;
        mul_b = {25'd0, mc[38:32]};
      end
      S_G4: begin
        mul_a = lnmag[31:0];
        mul_b = cfg.scale;
      end
      S_G5: begin
        mul_a = {24'd0, lnmag[39:32]};
        mul_b = cfg.scale;
      end
      S_E1: begin
        mul_a = mc[31:0];
        mul_b = mk;
      end
      S_E2: begin
        mul_a = {25'd0, mc[38:32]};
        mul_b = mk;
      end
      S_Q1: begin
        mul_a = q1[31:0];
        mul_b = cfg.scale;
      end
      S_Q2: begin
        mul_a = q1[63:32];
        mul_b = cfg.scale;
      end
      S_Q4: begin
        mul_a = cfg.scale;
        mul_b = r1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sreq = '0;
    case (state)
      S_IDLE: begin
        sreq.start = start && (sample > cfg.zero_fraction) && (cfg.zero_fraction != 32'd0);
        sreq.op    = SER_DIV;
        sreq.steps = 7'd32;
        sreq.num   = '0;
        sreq.den   = 32'd0 - cfg.zero_fraction;
        sreq.rem0  = sample - cfg.zero_fraction;
      end
      S_X1: begin
        sreq.start = 1'b1;
        sreq.op    = SER_SQRT;
        sreq.steps = 7'd32;
        sreq.num   = {rr, 31'd0};
      end
      S_X5: begin
        sreq.start = 1'b1;
        sreq.op    = SER_DIV;
        sreq.steps = 7'd64;
        sreq.num   = x;
        sreq.den   = mk;
      end
      S_Q5: begin
        sreq.start = 1'b1;
        sreq.op    = SER_DIV;
        sreq.steps = 7'd32;
        sreq.num   = {prod[31:0], 32'h0};
        sreq.den   = mk;
        sreq.rem0  = prod[63:32];
      end
      default: begin
        sreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (sample <= cfg.zero_fraction) begin
              val   <= '0;
              state <= S_DONE;
            end else if (cfg.zero_fraction == 32'd0) begin
              lx    <= {6'd0, sample};
              cexp  <= 6'd37;
              pass  <= 1'b0;
              state <= S_NORM;
            end else begin
              state <= S_DIVS;
            end
          end
        end
        S_DIVS: begin
          if (srsp.done) begin
            lx    <= {6'd0, srsp.quo[31:0]};
            cexp  <= 6'd37;
            pass  <= 1'b0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (lx[37]) begin
            m     <= lx[37:6];
            frac  <= '0;
            k     <= '0;
            state <= S_SQ;
          end else begin
            lx   <= {lx[36:0], 1'b0};
            cexp <= cexp - 6'd1;
          end
        end
        S_SQ: begin
          state <= S_SQW;
        end
        S_SQW: begin
          frac  <= {frac[30:0], sqt[32]};
          m     <= sqt[32] ? sqt[32:1] : sqt[31:0];
          k     <= k + 5'd1;
          state <= (k == 5'd31) ? S_LOGD : S_SQ;
        end
        S_LOGD: begin
          if (!pass) begin
            // Second pass takes the log of -log2(s).
            lx    <= A_BASE - lg;
            cexp  <= 6'd37;
            pass  <= 1'b1;
            state <= S_NORM;
          end else begin
            neg_c <= cval[40];
            mc    <= cval[40] ? cneg[38:0] : cval[38:0];
            state <= S_LOC;
          end
        end
        S_LOC: begin
          state <= S_LOCW;
        end
        S_LOCW: begin
          loc_t <= {{18{cfg.location[31]}}, cfg.location} + ploc;
          state <= (cfg.shape == 32'd0) ? S_G1 : S_E1;
        end
        S_G1: begin
          state <= S_G2;
        end
        S_G2: begin
          tlo   <= prod[63:32];
          state <= S_G3;
        end
        S_G3: begin
          lnmag <= prod[39:0] + {8'd0, tlo};
          state <= S_G4;
        end
        S_G4: begin
          state <= S_G5;
        end
        S_G5: begin
          tlo   <= prod[63:32];
          state <= S_G6;
        end
        S_G6: begin
          tmag     <= {10'd0, prod[40:0]} + {19'd0, tlo};
          term_neg <= !neg_c;
          state    <= S_FIN;
        end
        S_E1: begin
          state <= S_E2;
        end
        S_E2: begin
          elo   <= prod[63:28];
          state <= S_E3;
        end
        S_E3: begin
          if (cfg.scale == 32'd0) begin
            tmag     <= '0;
            term_neg <= 1'b0;
            state    <= S_FIN;
          end else if (e_sat) begin
            tmag     <= TERM_LIMIT;
            term_neg <= neg_k;
            state    <= S_FIN;
          end else begin
            f     <= e_val[31:0];
            n     <= e_val[44:32];
            r     <= 32'h8000_0000;
            j     <= '0;
            state <= S_X1;
          end
        end
        S_X1: begin
          state <= S_X2;
        end
        S_X2: begin
          if (srsp.done) begin
            r     <= srsp.root;
            j     <= j + 5'd1;
            state <= (j == 5'd31) ? S_X3 : S_X1;
          end
        end
        S_X3: begin
          pw    <= pw_calc;
          state <= S_X4;
        end
        S_X4: begin
          pos_pm1 <= !pm1[64];
          x       <= pm1[64] ? pm1_neg[63:0] : pm1[63:0];
          state   <= S_X5;
        end
        S_X5: begin
          state <= S_D1;
        end
        S_D1: begin
          if (srsp.done) begin
            q1    <= srsp.quo;
            r1    <= srsp.rem;
            state <= S_Q1;
          end
        end
        S_Q1: begin
          state <= S_Q2;
        end
        S_Q2: begin
          plo   <= prod;
          state <= S_Q3;
        end
        S_Q3: begin
          term_neg <= (!pos_pm1) != neg_k;
          if (full > PROD_LIMIT) begin
            tmag  <= TERM_LIMIT;
            state <= S_FIN;
          end else begin
            sq    <= full[54:0];
            state <= S_Q4;
          end
        end
        S_Q4: begin
          state <= S_Q5;
        end
        S_Q5: begin
          state <= S_Q6;
        end
        S_Q6: begin
          if (srsp.done) begin
            tmag  <= (qsh > {1'b0, TERM_LIMIT}) ? TERM_LIMIT : qsh[50:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (vsum[52]) begin
            val <= '0;
          end else if (vsum[51:32] != 20'd0) begin
            val <= 32'hFFFF_FFFF;
          end else begin
            val <= vsum[31:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle  = (state == S_IDLE);
  assign done  = (state == S_DONE);
  assign value = val;

endmodule

### sv/gev_block_maximum_sampler_top.sv
// Draws one block-maximum value per set from uniform Q0.32 samples by inverse-transform
// sampling of the GEV distribution (Gumbel when shape is zero), with a location that changes
// linearly with the position in the set, and reports the largest non-negative sample of each set in
// Q16.16 together with a flag on the final set of the run. One sample is worked on at a
// time on a single 32x32 multiplier and a bit-serial divide/square-root unit. A sample at or
// below the zero fraction gives zero directly; the Gumbel path runs the zero-fraction
// division, two normalisations and 64 squaring steps of the logarithms, and a nonzero shape
// adds to these, above all, the 32 square roots in the power of two.
// A finished set waits in the output register while the next sample is already taken.
module gev_block_maximum_sampler_top
  import gbms_pkg::*;
#(
  parameter int MAX_SET_LENGTH = 4096,
  parameter int FRACTION_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] uniform_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] set_maximum,
  output logic        last_set
);

  localparam int POS_W = (MAX_SET_LENGTH > 1) ? $clog2(MAX_SET_LENGTH) : 1;
  localparam logic [16:0] MAX_LEN = 17'(MAX_SET_LENGTH);

  gbms_cfg_t   cfg;
  logic [12:0] samples_per_set;
  logic [15:0] set_count;

  logic [POS_W-1:0] position_in_set;
  logic [31:0]      running_maximum;
  logic [15:0]      sets_done;

  logic        core_idle;
  logic        core_done;
  logic [31:0] core_value;
  logic        start;
  logic        take;
  logic [16:0] pos_plus1;
  logic [16:0] set_len;
  logic        set_end;
  logic        is_last;
  logic [31:0] new_max;

  always_comb begin
    pos_plus1 = 17'(position_in_set) + 17'd1;
    if (samples_per_set == 13'd0) begin
      set_len = 17'd1;
    end else if (17'(samples_per_set) > MAX_LEN) begin
      set_len = MAX_LEN;
    end else begin
      set_len = 17'(samples_per_set);
    end
    set_end = pos_plus1 >= set_len;
    is_last = (17'(sets_done) + 17'd1) >= 17'(set_count);
    new_max = (core_value > running_maximum) ? core_value : running_maximum;
    start   = in_valid && !in_stall;
    // A finishing set may only leave the core once the output register is free.
    take    = core_done && (!set_end || !out_valid || !out_stall);
  end

  assign in_stall = !core_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.location       <= '0;
      cfg.location_trend <= '0;
      cfg.scale          <= 32'(1) << FRACTION_BITS;
      cfg.shape          <= '0;
      cfg.zero_fraction  <= '0;
      samples_per_set    <= 13'd1;
      set_count          <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCATION:        cfg.location       <= cfg_data;
        REG_LOCATION_TREND:  cfg.location_trend <= cfg_data;
        REG_SCALE:           cfg.scale          <= cfg_data;
        REG_SHAPE:           cfg.shape          <= cfg_data;
        REG_ZERO_FRACTION:   cfg.zero_fraction  <= cfg_data;
        REG_SAMPLES_PER_SET: samples_per_set    <= cfg_data[12:0];
        REG_SET_COUNT:       set_count          <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_in_set <= '0;
      running_maximum <= '0;
      sets_done       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (set_end) begin
          out_valid       <= 1'b1;
          sets_done       <= is_last ? 16'd0 : sets_done + 16'd1;
          position_in_set <= '0;
          running_maximum <= '0;
        end else begin
          position_in_set <= position_in_set + POS_W'(1);
          running_maximum <= new_max;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && set_end) begin
      set_maximum <= new_max;
      last_set    <= is_last;
    end
  end

  gbms_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .sample    (uniform_sample),
    .pos_plus1 (pos_plus1),
    .cfg       (cfg),
    .take      (take),
    .idle      (core_idle),
    .done      (core_done),
    .value     (core_value)
  );

endmodule

### sv/gbms_checker.sv
module gbms_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] uniform_sample,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] set_maximum,
  input logic        last_set
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Each sample occupies the core, so the input is busy right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transaction");

  // A new set result only appears while a sample is being finished.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no sample in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(set_maximum) && $stable(last_set)))
    else $error("stalled result changed");

endmodule

bind gev_block_maximum_sampler_top gbms_checker u_gbms_checker (.*);

### verif/testbench.sv
module testbench;
  import gbms_pkg::*;

  localparam int          SET_LIMIT   = 4096;
  localparam int          LONG_SET    = 600;
  localparam int          SETTLE      = 2000;
  localparam int          STUCK_LIMIT = 60000;
  localparam bit [63:0]   LN2_Q32     = 64'hB172_17F7;
  localparam bit [63:0]   ONE_Q32     = 64'h1_0000_0000;
  localparam bit [63:0]   LOW_WORD    = 64'hFFFF_FFFF;
  localparam bit [63:0]   TERM_CAP    = 64'h4_0000_0000_0000;

  typedef struct {
    bit [31:0] set_maximum;
    bit        last_set;
  } set_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_LOCATION;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] uniform_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] set_maximum;
  logic        last_set;

  // Mirror of the configuration and of the block's own state.
  bit [31:0] m_location, m_trend, m_scale, m_shape, m_zero_frac;
  bit [12:0] m_set_len;
  bit [15:0] m_set_count;
  int unsigned pos_in_set, sets_done_cnt;
  bit [31:0] run_max;

  bit [31:0]   sample_queue[$];
  set_result_t pending_sets[$];
  int unsigned items_queued, items_taken;
  int unsigned failures;
  int unsigned burst_left, gap_left, stall_pct, stall_hold, stuck_cycles;

  gev_block_maximum_sampler_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .uniform_sample(uniform_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .set_maximum(set_maximum), .last_set(last_set)
  );

  always #4 clk = ~clk;

  function automatic longint sign32(bit [31:0] w);
    return longint'($signed(w));
  endfunction

  function automatic bit [63:0] log2_q32(bit [63:0] x);
    int c;
    bit [63:0] m, frac;
    c = 0;
    frac = 0;
    if (x == 0) return 0;
    for (int i = 0; i < 64; i++) if (x[i]) c = i;
    m = (c > 31) ? (x >> (c - 31)) : (x << (31 - c));
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= ONE_Q32) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(c) << 32) | frac;
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^f for a Q0.32 fraction, giving Q1.31.
  function automatic bit [63:0] pow2_fraction(bit [63:0] f);
    bit [63:0] r;
    r = 64'h8000_0000;
    for (int j = 0; j < 32; j++) begin
      if (f[j]) r = r << 1;
      r = floor_sqrt(r << 31);
    end
    return r;
  endfunction

  function automatic bit [31:0] gev_value(bit [31:0] u, int unsigned pos);
    bit [63:0] p, s, a, mc, tmag, lnmag, mk, emag, x, f, r, pw, q1, r1, sc;
    longint c, loc_t, term, v, k, e, n, sh, pm1;
    bit neg_c, neg_k, pos_pm1, sat;
    p = 64'(m_zero_frac);
    sc = 64'(m_scale);
    if (64'(u) <= p) return 0;
    s = (p != 0) ? (((64'(u) - p) << 32) / (ONE_Q32 - p)) : 64'(u);
    a = (64'd32 << 32) - log2_q32(s);
    c = $signed(log2_q32(a)) - (longint'(32) << 32)
      + $signed(log2_q32(LN2_Q32)) - (longint'(32) << 32);
    neg_c = c < 0;
    mc = neg_c ? 64'(-c) : 64'(c);
    loc_t = sign32(m_location) + sign32(m_trend) * longint'(pos + 1);
    k = sign32(m_shape);
    if (k == 0) begin
      lnmag = (mc >> 32) * LN2_Q32 + (((mc & LOW_WORD) * LN2_Q32) >> 32);
      tmag = (lnmag >> 32) * sc + (((lnmag & LOW_WORD) * sc) >> 32);
      term = neg_c ? $signed(tmag) : -$signed(tmag);
    end else begin
      neg_k = k < 0;
      pos_pm1 = 1'b1;
      sat = 1'b0;
      x = 0;
      mk = neg_k ? 64'(-k) : 64'(k);
      emag = (((mc >> 32) * mk) << 4) + (((mc & LOW_WORD) * mk) >> 28);
      e = (neg_c != neg_k) ? $signed(emag) : -$signed(emag);
      if (e >= (longint'(31) << 32)) begin
        sat = 1'b1;
      end else begin
        f = 64'(e) & LOW_WORD;
        r = pow2_fraction(f);
        n = (e - $signed(f)) / longint'(ONE_Q32);
        sh = n + 1;
        if (sh >= 0) pw = r << sh;
        else if (-sh >= 64) pw = 0;
        else pw = r >> (-sh);
        pm1 = $signed(pw) - $signed(ONE_Q32);
        pos_pm1 = pm1 >= 0;
        x = pos_pm1 ? 64'(pm1) : 64'(-pm1);
      end
      if (sc == 0) begin
        tmag = 0;
      end else if (sat) begin
        tmag = TERM_CAP;
      end else begin
        q1 = x / mk;
        r1 = x % mk;
        if (q1 > (TERM_CAP << 4) / sc) begin
          tmag = TERM_CAP;
        end else begin
          tmag = (sc * q1 + (sc * r1) / mk) >> 4;
          if (tmag > TERM_CAP) tmag = TERM_CAP;
        end
      end
      term = ((!pos_pm1) != neg_k) ? -$signed(tmag) : $signed(tmag);
    end
    v = loc_t + term;
    if (v < 0) return 0;
    if (64'(v) > LOW_WORD) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  // Advances the set state by one sample; returns 1 when a set closes.
  function automatic bit take_sample(bit [31:0] u, output set_result_t res);
    int unsigned len;
    bit [31:0] val;
    bit fin;
    len = (m_set_len == 0) ? 1 : int'(m_set_len);
    if (len > SET_LIMIT) len = SET_LIMIT;
    val = gev_value(u, pos_in_set);
    if (val > run_max) run_max = val;
    if (pos_in_set + 1 >= len) begin
      fin = (sets_done_cnt + 1) >= int'(m_set_count);
      res.set_maximum = run_max;
      res.last_set = fin;
      sets_done_cnt = fin ? 0 : ((sets_done_cnt + 1) & 16'hFFFF);
      pos_in_set = 0;
      run_max = 0;
      return 1'b1;
    end
    pos_in_set++;
    return 1'b0;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input bit [31:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      REG_LOCATION:        m_location = d;
      REG_LOCATION_TREND:  m_trend = d;
      REG_SCALE:           m_scale = d;
      REG_SHAPE:           m_shape = d;
      REG_ZERO_FRACTION:   m_zero_frac = d;
      REG_SAMPLES_PER_SET: m_set_len = d[12:0];
      REG_SET_COUNT:       m_set_count = d[15:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(input bit [31:0] loc, trend, sc, shp, zf, len, cnt);
    write_reg(REG_LOCATION, loc);
    write_reg(REG_LOCATION_TREND, trend);
    write_reg(REG_SCALE, sc);
    write_reg(REG_SHAPE, shp);
    write_reg(REG_ZERO_FRACTION, zf);
    write_reg(REG_SAMPLES_PER_SET, len);
    write_reg(REG_SET_COUNT, cnt);
    end_writes();
  endtask

  task automatic queue_sample(input bit [31:0] u);
    sample_queue.push_back(u);
    items_queued++;
  endtask

  // Holds off until every sample is taken and every set has come out, then lets
  // a sample with no set result finish inside the block.
  task automatic drain();
    do @(negedge clk);
    while (items_taken != items_queued || pending_sets.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic bit [31:0] rand_shape();
    case ($urandom_range(0, 4))
      0, 1: return 32'd0;
      2: return $urandom_range(0, 32'h0800_0000);
      3: return -$urandom_range(0, 32'h0800_0000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly plain uniform draws, with some at and around the zero fraction and some near full scale.
  function automatic bit [31:0] rand_uniform();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, m_zero_frac);
      1: return m_zero_frac + $urandom_range(0, 3);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Sender: bursts of random length with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 8;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_queue.size() != 0) begin
        in_valid <= 1'b1;
        uniform_sample <= sample_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall density is redrawn at random, zero included.
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_hold <= $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 20;
        2: stall_pct <= 50;
        default: stall_pct <= 90;
      endcase
    end else begin
      stall_hold <= stall_hold - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Prediction on accepted samples and checking of accepted sets.
  always @(posedge clk) begin
    set_result_t res, exp_res;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        items_taken <= items_taken + 1;
        if (take_sample(uniform_sample, res)) pending_sets.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (pending_sets.size() == 0) begin
          $error("set_maximum: unexpected transaction, value %h", set_maximum);
          failures++;
        end else begin
          exp_res = pending_sets.pop_front();
          if (set_maximum !== exp_res.set_maximum) begin
            $error("set_maximum: expected %h, got %h", exp_res.set_maximum, set_maximum);
            failures++;
          end
          if (last_set !== exp_res.last_set) begin
            $error("last_set: expected %0d, got %0d", exp_res.last_set, last_set);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    m_location = 0;
    m_trend = 0;
    m_scale = 32'h0001_0000;
    m_shape = 0;
    m_zero_frac = 0;
    m_set_len = 1;
    m_set_count = 1;
    pos_in_set = 0;
    sets_done_cnt = 0;
    run_max = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset settings: Gumbel with one sample per set, zero and full-scale samples.
    queue_sample(32'h0000_0000);
    queue_sample(32'h0000_0001);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h8000_0000);
    queue_sample(32'h5555_5555);
    queue_sample(32'hAAAA_AAAA);
    drain();

    // Largest positive shape and scale: the power saturates.
    program_all(32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 2, 3);
    queue_sample(32'h4000_0000);
    queue_sample(32'h4000_0001);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h4000_0100);
    queue_sample(32'h3FFF_FFFF);
    queue_sample(32'hC000_0000);
    drain();

    // Most negative shape, zero scale, extreme location and trend, zero set length
    // and zero set count.
    program_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 0, 0);
    for (int i = 0; i < 4; i++) queue_sample($urandom);
    drain();

    // Unit shape, high location with falling trend, set length above the limit
    // acting as the limit; one sample at the zero fraction and one just above it.
    program_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h1000_0000,
                32'hFFFF_FFFE, 32'h1FFF, 2);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'hFFFF_FFFE);
    drain();

    // Set length shrunk part way through a set.
    program_all(32'h0002_0000, 32'h0000_8000, 32'h0003_0000, 32'h0, 32'h1000_0000, 8, 4);
    for (int i = 0; i < 5; i++) queue_sample($urandom);
    drain();
    write_reg(REG_SAMPLES_PER_SET, 3);
    end_writes();
    for (int i = 0; i < 3; i++) queue_sample($urandom);
    drain();

    // One long set, kept quick by a high zero fraction.
    program_all($urandom, $urandom_range(0, 32'h100), 32'h0002_0000, 32'h0,
                32'hF000_0000, LONG_SET, 1);
    for (int i = 0; i < LONG_SET; i++) queue_sample($urandom);
    drain();

    // Random settings with mostly short sets.
    for (int ph = 0; ph < 11; ph++) begin
      program_all(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h2_0000) - 32'h1_0000,
                  ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000),
                  rand_shape(),
                  ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom,
                  $urandom_range(0, 12),
                  $urandom_range(0, 5));
      for (int i = 0; i < 40; i++) queue_sample(rand_uniform());
      drain();
    end

    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
